### sv/bch_pkg.sv
// Shared types and constants of the byte class histogram.
`default_nettype none
package bch_pkg;

  // Widths fixed by the result fields and the configuration registers
  localparam int OUT_W      = 32;
  localparam int LEVEL_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Defaults of the top-level parameters
  localparam int COUNT_WIDTH_DEF     = 32;
  localparam int RATIO_FRAC_BITS_DEF = 8;

  // Queue between front and back
  localparam int QDEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_CHECK_ON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENFORCE_MODE  = 2'd2;

  // Configuration reset values
  localparam logic [LEVEL_W-1:0] CODE_LEVEL_RST    = 16'd64;
  localparam logic               CODE_CHECK_ON_RST = 1'b1;
  localparam logic               ENFORCE_MODE_RST  = 1'b0;

  // Character constants
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_DIGIT,
    CLS_SPACE,
    CLS_CTRL,
    CLS_PUNCT,
    CLS_HIGH
  } cls_t;

  // One queued item: its class and the end-of-string mark
  typedef struct packed {
    cls_t cls;
    logic last;
  } qent_t;

  // Status marks
  typedef struct packed {
    logic err;
    logic nonascii;
    logic code;
    logic ctrl;
  } flags_t;

  // Configuration as seen by the back end
  typedef struct packed {
    logic [LEVEL_W-1:0] code_level;
    logic               code_check_on;
    logic               enforce_mode;
  } cfg_t;

endpackage
`default_nettype wire

### sv/bch_front.sv
// Front end: accept bytes and classify them into the queue.
`default_nettype none
module bch_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_string_end,
  input  wire logic          q_full,
  output logic               q_push,
  output bch_pkg::qent_t     q_wdata
);

  function automatic bch_pkg::cls_t classify(input logic [7:0] c);
    bch_pkg::cls_t k;
    if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
      k = bch_pkg::CLS_LETTER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      k = bch_pkg::CLS_DIGIT;
    end else if (c == bch_pkg::CH_SPACE || c == bch_pkg::CH_TAB ||
                 c == bch_pkg::CH_CR || c == bch_pkg::CH_LF) begin
      k = bch_pkg::CLS_SPACE;
    end else if (c < bch_pkg::CH_SPACE || c == bch_pkg::CH_DEL) begin
      k = bch_pkg::CLS_CTRL;
    end else if (c < bch_pkg::CH_DEL) begin
      k = bch_pkg::CLS_PUNCT;
    end else begin
      k = bch_pkg::CLS_HIGH;
    end
    return k;
  endfunction

  assign in_ready      = !q_full;
  assign q_push        = in_valid && !q_full;
  assign q_wdata.cls   = classify(in_data_byte);
  assign q_wdata.last  = in_string_end;

endmodule
`default_nettype wire

### sv/bch_queue.sv
// Short queue of classified items between front and back.
`default_nettype none
module bch_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bch_pkg::qent_t  wdata,
  output logic                 full,
  output logic                 rvalid,
  input  wire logic            pop,
  output bch_pkg::qent_t       rdata
);

  localparam int PTR_W = $clog2(bch_pkg::QDEPTH);
  localparam int CNT_W = $clog2(bch_pkg::QDEPTH + 1);

  bch_pkg::qent_t    mem_r [bch_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(bch_pkg::QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full   = (cnt_r == CNT_W'(bch_pkg::QDEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### sv/bch_back.sv
// Back end: counters, ratio test, status marks and the result register.
`default_nettype none
module bch_back #(
  parameter int COUNT_WIDTH     = bch_pkg::COUNT_WIDTH_DEF,
  parameter int RATIO_FRAC_BITS = bch_pkg::RATIO_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bch_pkg::cfg_t                cfg,
  input  wire logic                         q_valid,
  output logic                              q_ready,
  input  wire bch_pkg::qent_t               q_rdata,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [bch_pkg::OUT_W-1:0]         out_total_count,
  output logic [bch_pkg::OUT_W-1:0]         out_letter_count,
  output logic [bch_pkg::OUT_W-1:0]         out_digit_count,
  output logic [bch_pkg::OUT_W-1:0]         out_space_count,
  output logic [bch_pkg::OUT_W-1:0]         out_ctrl_count,
  output logic [bch_pkg::OUT_W-1:0]         out_punct_count,
  output logic [bch_pkg::OUT_W-1:0]         out_high_count,
  output logic                              out_ctrl_flag,
  output logic                              out_code_flag,
  output logic                              out_nonascii_flag,
  output logic                              out_error_flag,
  output logic                              out_byte_skipped
);

  localparam int CW  = COUNT_WIDTH;
  localparam int OW  = bch_pkg::OUT_W;
  // Product width: (CW+1)-bit sum times the level; also holds punct << F
  localparam int PW  = CW + 1 + bch_pkg::LEVEL_W;

  logic [CW-1:0] total_r,  total_nxt;
  logic [CW-1:0] letter_r, letter_nxt;
  logic [CW-1:0] digit_r,  digit_nxt;
  logic [CW-1:0] space_r,  space_nxt;
  logic [CW-1:0] ctrl_r,   ctrl_nxt;
  logic [CW-1:0] punct_r,  punct_nxt;
  logic [CW-1:0] high_r,   high_nxt;
  bch_pkg::flags_t flags_r, flags_nxt;
  logic          skip_r,   skip_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          skipped;
  logic          reject;
  logic          fire;

  logic [CW-1:0] punct_inc;
  logic [CW:0]   den_sum;
  logic [PW-1:0] lhs;
  logic [PW-1:0] rhs;
  logic          above;

  logic [OW-1:0] total_o_r, letter_o_r, digit_o_r, space_o_r;
  logic [OW-1:0] ctrl_o_r, punct_o_r, high_o_r;
  bch_pkg::flags_t flags_o_r;
  logic          skipped_o_r;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (c == {CW{1'b1}}) ? c : c + CW'(1);
  endfunction

  function automatic logic [OW-1:0] show(input logic [CW-1:0] c);
    logic [63:0] e;
    e = 64'(c);
    return (e > 64'h0000_0000_FFFF_FFFF) ? {OW{1'b1}} : e[OW-1:0];
  endfunction

  assign q_ready = !out_valid_r || out_ready;
  assign fire    = q_valid && q_ready;

  // Ratio test punct/(letters+high) > level/2^F, cross-multiplied
  always_comb begin
    punct_inc = sat_inc(punct_r);
    den_sum   = {1'b0, letter_r} + {1'b0, high_r};
    lhs       = PW'(punct_inc) << RATIO_FRAC_BITS;
    rhs       = PW'(den_sum) * PW'(cfg.code_level);
    above     = lhs > rhs;
  end

  always_comb begin
    total_nxt  = total_r;
    letter_nxt = letter_r;
    digit_nxt  = digit_r;
    space_nxt  = space_r;
    ctrl_nxt   = ctrl_r;
    punct_nxt  = punct_r;
    high_nxt   = high_r;
    flags_nxt  = flags_r;
    skip_nxt   = skip_r;
    skipped    = 1'b0;
    reject     = 1'b0;
    if (fire) begin
      if (skip_r) begin
        skipped  = 1'b1;
        skip_nxt = !q_rdata.last;
      end else begin
        total_nxt = sat_inc(total_r);
        unique case (q_rdata.cls)
          bch_pkg::CLS_LETTER: letter_nxt = sat_inc(letter_r);
          bch_pkg::CLS_DIGIT:  digit_nxt  = sat_inc(digit_r);
          bch_pkg::CLS_SPACE:  space_nxt  = sat_inc(space_r);
          bch_pkg::CLS_CTRL: begin
            ctrl_nxt       = sat_inc(ctrl_r);
            flags_nxt.ctrl = 1'b1;
            reject         = cfg.enforce_mode;
          end
          bch_pkg::CLS_PUNCT: begin
            punct_nxt = punct_inc;
            if (cfg.code_check_on && above) begin
              flags_nxt.code = 1'b1;
              reject         = cfg.enforce_mode;
            end else begin
              flags_nxt.code = 1'b0;
            end
          end
          bch_pkg::CLS_HIGH: begin
            high_nxt           = sat_inc(high_r);
            flags_nxt.nonascii = 1'b1;
          end
          default: ;
        endcase
        if (reject) begin
          flags_nxt.err = 1'b1;
          skip_nxt      = !q_rdata.last;
        end
      end
    end
    out_valid_nxt = q_ready ? fire : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      letter_r    <= '0;
      digit_r     <= '0;
      space_r     <= '0;
      ctrl_r      <= '0;
      punct_r     <= '0;
      high_r      <= '0;
      flags_r     <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      letter_r    <= letter_nxt;
      digit_r     <= digit_nxt;
      space_r     <= space_nxt;
      ctrl_r      <= ctrl_nxt;
      punct_r     <= punct_nxt;
      high_r      <= high_nxt;
      flags_r     <= flags_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register: load on every item taken from the queue
  always_ff @(posedge clk) begin
    if (fire) begin
      total_o_r   <= show(total_nxt);
      letter_o_r  <= show(letter_nxt);
      digit_o_r   <= show(digit_nxt);
      space_o_r   <= show(space_nxt);
      ctrl_o_r    <= show(ctrl_nxt);
      punct_o_r   <= show(punct_nxt);
      high_o_r    <= show(high_nxt);
      flags_o_r   <= flags_nxt;
      skipped_o_r <= skipped;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_total_count   = total_o_r;
  assign out_letter_count  = letter_o_r;
  assign out_digit_count   = digit_o_r;
  assign out_space_count   = space_o_r;
  assign out_ctrl_count    = ctrl_o_r;
  assign out_punct_count   = punct_o_r;
  assign out_high_count    = high_o_r;
  assign out_ctrl_flag     = flags_o_r.ctrl;
  assign out_code_flag     = flags_o_r.code;
  assign out_nonascii_flag = flags_o_r.nonascii;
  assign out_error_flag    = flags_o_r.err;
  assign out_byte_skipped  = skipped_o_r;

endmodule
`default_nettype wire

### sv/byte_class_histogram.sv
// Top level of the byte class histogram: configuration, front, queue, back.
//
// Usage: feed one text byte per item on the in_ channel (in_data_byte, with
// in_string_end marking the last byte of a string). Every accepted item
// gives exactly one result item on the out_ channel: the seven saturating
// counters after this byte, the four status marks and byte_skipped.
// Configuration writes on the cfg_ channel (index 0 code_level, 1
// code_check_on, 2 enforce_mode, others ignored) are always taken at once;
// write them only while no item is in flight.
// Flow: classify into the queue at the input accept edge, then count and
// test in the back end, which registers the result and raises out_valid.
// Throughput: one item per cycle while the receiver does not stall, set by
// the back end's counter update and cross-multiply compare; the two-entry
// queue keeps the input open while a result waits, until the queue is full.
// Reset (rst_n low, synchronous): counters, marks and skipping clear, the
// queue empties, configuration returns to its reset values.
// Receiver stall: the result register holds, the back end stops, the queue
// fills and in_ready drops when it is full; no item is lost.
`default_nettype none
module byte_class_histogram #(
  parameter int COUNT_WIDTH     = bch_pkg::COUNT_WIDTH_DEF,
  parameter int RATIO_FRAC_BITS = bch_pkg::RATIO_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_data_byte,
  input  wire logic                              in_string_end,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bch_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [bch_pkg::OUT_W-1:0]              out_total_count,
  output logic [bch_pkg::OUT_W-1:0]              out_letter_count,
  output logic [bch_pkg::OUT_W-1:0]              out_digit_count,
  output logic [bch_pkg::OUT_W-1:0]              out_space_count,
  output logic [bch_pkg::OUT_W-1:0]              out_ctrl_count,
  output logic [bch_pkg::OUT_W-1:0]              out_punct_count,
  output logic [bch_pkg::OUT_W-1:0]              out_high_count,
  output logic                                   out_ctrl_flag,
  output logic                                   out_code_flag,
  output logic                                   out_nonascii_flag,
  output logic                                   out_error_flag,
  output logic                                   out_byte_skipped
);

  bch_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           q_full;
  logic           q_push;
  bch_pkg::qent_t q_wdata;
  logic           q_valid;
  logic           q_ready;
  bch_pkg::qent_t q_rdata;

  // Configuration registers: always ready, mask data to register width
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bch_pkg::CFG_CODE_LEVEL:
          cfg_nxt.code_level = cfg_data[bch_pkg::LEVEL_W-1:0];
        bch_pkg::CFG_CODE_CHECK_ON:
          cfg_nxt.code_check_on = cfg_data[0];
        bch_pkg::CFG_ENFORCE_MODE:
          cfg_nxt.enforce_mode = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_level    <= bch_pkg::CODE_LEVEL_RST;
      cfg_r.code_check_on <= bch_pkg::CODE_CHECK_ON_RST;
      cfg_r.enforce_mode  <= bch_pkg::ENFORCE_MODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify incoming items and push them into the queue
  bch_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_string_end (in_string_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  // Decouple front and back
  bch_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .rvalid (q_valid),
    .pop    (q_valid && q_ready),
    .rdata  (q_rdata)
  );

  // Count, test the punctuation ratio and drive the result register
  bch_back #(
    .COUNT_WIDTH     (COUNT_WIDTH),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_rdata           (q_rdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_total_count   (out_total_count),
    .out_letter_count  (out_letter_count),
    .out_digit_count   (out_digit_count),
    .out_space_count   (out_space_count),
    .out_ctrl_count    (out_ctrl_count),
    .out_punct_count   (out_punct_count),
    .out_high_count    (out_high_count),
    .out_ctrl_flag     (out_ctrl_flag),
    .out_code_flag     (out_code_flag),
    .out_nonascii_flag (out_nonascii_flag),
    .out_error_flag    (out_error_flag),
    .out_byte_skipped  (out_byte_skipped)
  );

  // A skipped byte only follows a raised error mark
  a_skip_needs_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_skipped |-> out_error_flag)
    else $error("byte skipped without error mark");

  // The error mark never clears once a result has shown it
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid) && $past(out_error_flag) |-> out_error_flag)
    else $error("error mark cleared");

  // A result is either held from a stall or freshly taken from the queue
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(q_valid && q_ready) || $past(out_valid && !out_ready))
    else $error("result without queued item");

  // The input only stalls when the queue holds items
  a_stall_needs_items: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("input stalled with empty queue");

endmodule
`default_nettype wire

### dv/byte_class_histogram_test.sv
// Self-checking testbench of the byte class histogram: directed and random text against a predictor.
module byte_class_histogram_test;
  import bch_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int HALF_PERIOD = CLK_PERIOD / 2;
  // The block decodes only three registers; this index must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // One result item as the block should present it
  typedef struct {
    logic [OUT_W-1:0] total;
    logic [OUT_W-1:0] letters;
    logic [OUT_W-1:0] digits;
    logic [OUT_W-1:0] spaces;
    logic [OUT_W-1:0] ctrls;
    logic [OUT_W-1:0] puncts;
    logic [OUT_W-1:0] highs;
    logic             ctrl_f;
    logic             code_f;
    logic             nonascii_f;
    logic             error_f;
    logic             skipped;
  } tally_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_data_byte = '0;
  logic                  in_string_end = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [OUT_W-1:0]      out_total_count;
  logic [OUT_W-1:0]      out_letter_count;
  logic [OUT_W-1:0]      out_digit_count;
  logic [OUT_W-1:0]      out_space_count;
  logic [OUT_W-1:0]      out_ctrl_count;
  logic [OUT_W-1:0]      out_punct_count;
  logic [OUT_W-1:0]      out_high_count;
  logic                  out_ctrl_flag;
  logic                  out_code_flag;
  logic                  out_nonascii_flag;
  logic                  out_error_flag;
  logic                  out_byte_skipped;

  // Predictor state: counters, marks, skipping and its copy of the registers
  logic [OUT_W-1:0]   cnt_total, cnt_letter, cnt_digit, cnt_space;
  logic [OUT_W-1:0]   cnt_ctrl, cnt_punct, cnt_high;
  logic               flag_ctrl, flag_code, flag_nonascii, flag_error;
  logic               skipping;
  logic [LEVEL_W-1:0] cur_level;
  logic               cur_check_on;
  logic               cur_enforce;

  // Results still owed by the block, oldest first
  tally_t pending_tallies[$];
  tally_t head;

  int mismatches = 0;
  int bytes_sent = 0;
  int strings_ended = 0;
  int results_seen = 0;
  int skips_seen = 0;
  int cfg_writes = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  byte_class_histogram u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_string_end     (in_string_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_total_count   (out_total_count),
    .out_letter_count  (out_letter_count),
    .out_digit_count   (out_digit_count),
    .out_space_count   (out_space_count),
    .out_ctrl_count    (out_ctrl_count),
    .out_punct_count   (out_punct_count),
    .out_high_count    (out_high_count),
    .out_ctrl_flag     (out_ctrl_flag),
    .out_code_flag     (out_code_flag),
    .out_nonascii_flag (out_nonascii_flag),
    .out_error_flag    (out_error_flag),
    .out_byte_skipped  (out_byte_skipped)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic cls_t classify(input logic [7:0] b);
    if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) return CLS_LETTER;
    if (b >= "0" && b <= "9") return CLS_DIGIT;
    if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) return CLS_SPACE;
    if (b < CH_SPACE || b == CH_DEL) return CLS_CTRL;
    if (b < CH_DEL) return CLS_PUNCT;
    return CLS_HIGH;
  endfunction

  // Hold at the top instead of wrapping
  function automatic logic [OUT_W-1:0] bump(input logic [OUT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // punct / (letters + high) > level / 2^F, cross-multiplied so that a zero
  // denominator always counts as above
  function automatic logic ratio_above();
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = 64'(cnt_punct) << RATIO_FRAC_BITS_DEF;
    rhs = (64'(cnt_letter) + 64'(cnt_high)) * 64'(cur_level);
    return lhs > rhs;
  endfunction

  function automatic void clear_model();
    cnt_total = '0;
    cnt_letter = '0;
    cnt_digit = '0;
    cnt_space = '0;
    cnt_ctrl = '0;
    cnt_punct = '0;
    cnt_high = '0;
    {flag_ctrl, flag_code, flag_nonascii, flag_error} = '0;
    skipping = 1'b0;
    cur_level = CODE_LEVEL_RST;
    cur_check_on = CODE_CHECK_ON_RST;
    cur_enforce = ENFORCE_MODE_RST;
  endfunction

  // Advance the predictor by one accepted byte and queue the result it owes
  function automatic void tally_byte(input logic [7:0] b, input logic last);
    tally_t t;
    logic reject;
    reject = 1'b0;
    t.skipped = 1'b0;
    if (skipping) begin
      t.skipped = 1'b1;
      if (last) skipping = 1'b0;
    end else begin
      cnt_total = bump(cnt_total);
      case (classify(b))
        CLS_LETTER: cnt_letter = bump(cnt_letter);
        CLS_DIGIT:  cnt_digit = bump(cnt_digit);
        CLS_SPACE:  cnt_space = bump(cnt_space);
        CLS_CTRL: begin
          cnt_ctrl = bump(cnt_ctrl);
          flag_ctrl = 1'b1;
          reject = cur_enforce;
        end
        CLS_PUNCT: begin
          cnt_punct = bump(cnt_punct);
          if (cur_check_on && ratio_above()) begin
            flag_code = 1'b1;
            reject = cur_enforce;
          end else begin
            flag_code = 1'b0;
          end
        end
        default: begin
          cnt_high = bump(cnt_high);
          flag_nonascii = 1'b1;
        end
      endcase
      // The rejecting byte still counts; skipping starts on the next one
      // unless this byte already closes the string
      if (reject) begin
        flag_error = 1'b1;
        if (!last) skipping = 1'b1;
      end
    end
    t.total = cnt_total;
    t.letters = cnt_letter;
    t.digits = cnt_digit;
    t.spaces = cnt_space;
    t.ctrls = cnt_ctrl;
    t.puncts = cnt_punct;
    t.highs = cnt_high;
    t.ctrl_f = flag_ctrl;
    t.code_f = flag_code;
    t.nonascii_f = flag_nonascii;
    t.error_f = flag_error;
    pending_tallies.push_back(t);
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [OUT_W-1:0] want,
                                      input logic [OUT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every accepted result with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_tallies.size() == 0) begin
        $error("result item arrived with no byte waiting for it");
        mismatches++;
      end else begin
        head = pending_tallies.pop_front();
        if (head.skipped) skips_seen++;
        check_field("total_count", head.total, out_total_count);
        check_field("letter_count", head.letters, out_letter_count);
        check_field("digit_count", head.digits, out_digit_count);
        check_field("space_count", head.spaces, out_space_count);
        check_field("ctrl_count", head.ctrls, out_ctrl_count);
        check_field("punct_count", head.puncts, out_punct_count);
        check_field("high_count", head.highs, out_high_count);
        check_field("ctrl_flag", OUT_W'(head.ctrl_f), OUT_W'(out_ctrl_flag));
        check_field("code_flag", OUT_W'(head.code_f), OUT_W'(out_code_flag));
        check_field("nonascii_flag", OUT_W'(head.nonascii_f), OUT_W'(out_nonascii_flag));
        check_field("error_flag", OUT_W'(head.error_f), OUT_W'(out_error_flag));
        check_field("byte_skipped", OUT_W'(head.skipped), OUT_W'(out_byte_skipped));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Idling on both sides
  // ---------------------------------------------------------------------

  // Mostly a short gap, now and then a long stretch
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result channel at random; stall_pct 0 keeps it always open
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------------
  // Channel tasks
  // ---------------------------------------------------------------------

  // Offer one byte, hold it until taken, then predict its result. Valid is
  // left high so that a byte sent straight after follows with no gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = b;
    in_string_end = last;
    do @(posedge clk); while (!in_ready);
    tally_byte(b, last);
    bytes_sent++;
    if (last) strings_ended++;
  endtask

  // Drop valid and wait until every owed result is in, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; only call while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CODE_LEVEL:    cur_level = val;
      CFG_CODE_CHECK_ON: cur_check_on = val[0];
      CFG_ENFORCE_MODE:  cur_enforce = val[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset settings: class edges, both ends of the byte range, and a
  // punctuation byte before any letter so the ratio has a zero denominator
  task automatic test_char_classes();
    send_byte("!", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(CH_DEL, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte("A", 1'b0);
    send_byte("z", 1'b0);
    send_byte("0", 1'b0);
    send_byte("9", 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte("/", 1'b0);
    send_byte("@", 1'b0);
    send_byte("{", 1'b0);
    send_byte("~", 1'b1);
    settle();
  endtask

  // With the ratio test off any punctuation byte clears the code mark;
  // a write to the unmapped index must change nothing
  task automatic test_ratio_disabled();
    write_reg(CFG_CODE_LEVEL, 16'h0000);
    send_byte("#", 1'b1);
    settle();
    write_reg(CFG_CODE_CHECK_ON, 16'hFFFE);
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    send_byte("%", 1'b1);
    settle();
    write_reg(CFG_CODE_CHECK_ON, 16'h0001);
  endtask

  // Enforce mode: a control byte mid-string, one at the end of a string,
  // and a code-mark punctuation byte; then leave enforce mode with the
  // error mark still held
  task automatic test_enforce();
    write_reg(CFG_ENFORCE_MODE, 16'h0001);
    send_byte("a", 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b1);
    send_byte(8'h02, 1'b1);
    send_byte("d", 1'b0);
    send_byte("$", 1'b0);
    send_byte("&", 1'b1);
    settle();
    write_reg(CFG_ENFORCE_MODE, 16'h0000);
    write_reg(CFG_CODE_LEVEL, CODE_LEVEL_RST);
    send_byte("e", 1'b1);
    settle();
  endtask

  // Draw a byte weighted towards text, with some fully random ones
  function automatic logic [7:0] random_text_byte();
    logic [7:0] b;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4: b = $urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                              : 8'($urandom_range("A", "Z"));
      5: b = 8'($urandom_range("0", "9"));
      6: case ($urandom_range(0, 3))
           0:       b = CH_SPACE;
           1:       b = CH_TAB;
           2:       b = CH_CR;
           default: b = CH_LF;
         endcase
      7, 8, 9: do b = 8'($urandom_range(33, 126)); while (classify(b) != CLS_PUNCT);
      10: do b = 8'($urandom_range(0, 32)); while (classify(b) != CLS_CTRL && b != CH_SPACE);
      11: b = 8'($urandom_range(128, 255));
      default: b = 8'($urandom_range(0, 255));
    endcase
    // Fold the odd space drawn above into the delete byte
    if (b == CH_SPACE && $urandom_range(0, 1)) b = CH_DEL;
    return b;
  endfunction

  // Random strings in phases, each with its own settings and idling mix
  task automatic test_random_text(input int n_items);
    int per_phase;
    int sent;
    int len;
    logic [LEVEL_W-1:0] lvl;
    per_phase = n_items / 8;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       lvl = '0;
        1:       lvl = '1;
        default: case ($urandom_range(0, 5))
                   0:       lvl = 16'd64;
                   1:       lvl = 16'd128;
                   2:       lvl = 16'd256;
                   3:       lvl = 16'd384;
                   4:       lvl = 16'd1;
                   default: lvl = 16'($urandom_range(0, 16'hFFFF));
                 endcase
      endcase
      write_reg(CFG_CODE_LEVEL, lvl);
      write_reg(CFG_CODE_CHECK_ON, (ph == 3) ? 16'h0000 : 16'h0001);
      write_reg(CFG_ENFORCE_MODE, 16'(ph[0]));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNMAPPED, 16'($urandom_range(0, 16'hFFFF)));
      // Idling mix: none, sender only, receiver only, receiver only
      send_gap_pct = ph[1] ? 0 : 30;
      stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 30 : 0;
      if (ph % 4 == 0) begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
      sent = 0;
      while (sent < per_phase) begin
        if ($urandom_range(0, 99) < 15) begin
          // Broken framing: end marks at random
          send_byte(random_text_byte(), 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++) send_byte(random_text_byte(), i == len - 1);
          sent += len;
        end
      end
      settle();
    end
    send_gap_pct = 0;
    stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    clear_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_gap_pct = 20;
    stall_pct = 20;
    test_char_classes();
    test_ratio_disabled();
    test_enforce();
    test_random_text(800);
    settle();
    $display("Sent %0d bytes in %0d ended strings; %0d results checked, %0d of them skipped.",
             bytes_sent, strings_ended, results_seen, skips_seen);
    $display("Made %0d register writes over the directed tests and eight random phases, %0d mismatches.",
             cfg_writes, mismatches);
    if (mismatches == 0 && pending_tallies.size() == 0) begin
      $display("byte_class_histogram regression: pass");
    end else begin
      if (pending_tallies.size() != 0)
        $error("%0d results never arrived", pending_tallies.size());
      $display("byte_class_histogram regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(CLK_PERIOD * 400000);
    $display("byte_class_histogram regression: fail");
    $finish;
  end

endmodule
